>>> src/flts_pkg.sv
package flts_pkg;

  localparam int GRID_W      = 256;
  localparam int GRID_H      = 256;
  localparam int COS_ENTRIES = 1024;

  localparam int COL_W  = $clog2(GRID_W);
  localparam int ROW_W  = $clog2(GRID_H);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int CELLS  = GRID_W * GRID_H;
  localparam int IDX_W  = $clog2(COS_ENTRIES);

  localparam int H_W       = 32;
  localparam int BAND_W    = 24;
  localparam int STEP_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int FLT_W     = 16;
  localparam int COS_W     = 10;
  localparam int CRD_W     = 8;
  localparam int PROD_W    = 28;
  localparam int BANDS_W   = 34;

  localparam logic [CFG_IDX_W-1:0] CFG_BAND_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd2;

  localparam logic [BAND_W-1:0] BAND_START_RST = 24'd3840000;
  localparam logic [STEP_W-1:0] BAND_STEP_RST  = 16'd5248;
  localparam logic [GAIN_W-1:0] GAIN_RST       = 16'd717;

  localparam logic [21:0]      FALL_Q8   = 22'd51;
  localparam logic [COS_W:0]   RISE_BIAS = 11'd205;

  localparam longint unsigned Q28_ONE = 64'd268435456;
  localparam longint unsigned PI_Q28  = 64'd843314856;

  typedef logic signed [COS_W-1:0] cos_t;
  typedef cos_t cos_tab_t [COS_ENTRIES];

  // cosine over half a turn, Q.8, Taylor series on the folded angle
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t        t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned r;
    longint unsigned sub;
    longint unsigned kk;
    longint unsigned q8;
    bit              neg;
    for (int k = 0; k < COS_ENTRIES; k++) begin
      neg = (2 * k > COS_ENTRIES);
      kk  = neg ? longint'(COS_ENTRIES - k) : longint'(k);
      x   = (PI_Q28 * kk) / COS_ENTRIES;
      x2  = (x * x) >> 28;
      r   = Q28_ONE;
      sub = ((x2 * r) >> 28) / 90;
      r   = (sub >= Q28_ONE) ? 64'd0 : Q28_ONE - sub;
      sub = ((x2 * r) >> 28) / 56;
      r   = (sub >= Q28_ONE) ? 64'd0 : Q28_ONE - sub;
      sub = ((x2 * r) >> 28) / 30;
      r   = (sub >= Q28_ONE) ? 64'd0 : Q28_ONE - sub;
      sub = ((x2 * r) >> 28) / 12;
      r   = (sub >= Q28_ONE) ? 64'd0 : Q28_ONE - sub;
      sub = ((x2 * r) >> 28) / 2;
      r   = (sub >= Q28_ONE) ? 64'd0 : Q28_ONE - sub;
      q8   = (r + (64'd1 << 19)) >> 20;
      t[k] = neg ? -cos_t'(q8) : cos_t'(q8);
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

  typedef struct packed {
    logic             clr_we;
    logic             issue;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             rd_req;
    logic             latch;
    logic             band_mul;
    logic             band_sub;
    logic             load_read;
    logic             load_fault;
  } cmd_t;

  typedef struct packed {
    logic pipe_idle;
    logic out_free;
  } sts_t;

endpackage

>>> src/flts_ram.sv
module flts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/flts_ctrl.sv
module flts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  logic           in_read_i,
  input  flts_pkg::sts_t sts_i,
  output flts_pkg::cmd_t cmd_o,
  output logic           in_ready_o
);
  import flts_pkg::*;

  typedef enum logic [8:0] {
    ST_CLEAR    = 9'b000000001,
    ST_IDLE     = 9'b000000010,
    ST_READ     = 9'b000000100,
    ST_BAND_MUL = 9'b000001000,
    ST_BAND_SUB = 9'b000010000,
    ST_RUN      = 9'b000100000,
    ST_DRAIN    = 9'b001000000,
    ST_RESP     = 9'b010000000,
    ST_SPARE    = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             step;
  logic             last_cell;

  assign last_cell = (col_q == COL_W'(GRID_W - 1)) && (row_q == ROW_W'(GRID_H - 1));

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.col  = col_q;
    cmd_o.row  = row_q;
    in_ready_o = 1'b0;
    step       = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        step         = 1'b1;
        if (last_cell) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          if (in_read_i) begin
            cmd_o.rd_req = 1'b1;
            state_d      = ST_READ;
          end else begin
            cmd_o.latch = 1'b1;
            state_d     = ST_BAND_MUL;
          end
        end
      end
      ST_READ: begin
        if (sts_i.out_free) begin
          cmd_o.load_read = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_BAND_MUL: begin
        cmd_o.band_mul = 1'b1;
        state_d        = ST_BAND_SUB;
      end
      ST_BAND_SUB: begin
        cmd_o.band_sub = 1'b1;
        state_d        = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        step        = 1'b1;
        if (last_cell) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts_i.pipe_idle) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_fault = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // walk the grid row by row
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (step) begin
      if (col_q == COL_W'(GRID_W - 1)) begin
        col_d = '0;
        row_d = (row_q == ROW_W'(GRID_H - 1)) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

`ifndef SYNTHESIS
  a_drain_at_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (col_q == '0) && (row_q == '0))
    else $error("grid walk not back at origin while draining");
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_read || cmd_o.load_fault) |-> sts_i.out_free)
    else $error("result loaded over a pending item");
  a_read_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && in_read_i) |=> (state_q == ST_READ))
    else $error("read item not followed by read state");
  a_clear_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q == ST_CLEAR) |-> (state_q == ST_IDLE))
    else $error("clear sweep left to wrong state");
`endif

endmodule

>>> src/flts_dp.sv
module flts_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  flts_pkg::cmd_t                 cmd_i,
  output flts_pkg::sts_t                 sts_o,
  input  logic                           cfg_we_i,
  input  logic [flts_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [flts_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [flts_pkg::CRD_W-1:0]     start_col_i,
  input  logic [flts_pkg::CRD_W-1:0]     start_row_i,
  input  logic [flts_pkg::CRD_W-1:0]     end_col_i,
  input  logic [flts_pkg::CRD_W-1:0]     end_row_i,
  input  logic [flts_pkg::CRD_W-1:0]     read_col_i,
  input  logic [flts_pkg::CRD_W-1:0]     read_row_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [flts_pkg::H_W-1:0]       height_value_o,
  output logic                           fault_done_o,
  output logic                           saturated_o
);
  import flts_pkg::*;

  typedef struct packed {
    logic                     vld;
    logic [ADDR_W-1:0]        addr;
    logic signed [2*CRD_W+1:0] p1;
    logic signed [2*CRD_W+1:0] p2;
  } prod_st_t;

  typedef struct packed {
    logic              vld;
    logic              in_band;
    logic [ADDR_W-1:0] addr;
    logic [BAND_W-1:0] rem;
    logic [IDX_W-1:0]  quo;
  } div_st_t;

  typedef struct packed {
    logic              vld;
    logic              in_band;
    logic [ADDR_W-1:0] addr;
    cos_t              cosv;
  } cos_st_t;

  typedef struct packed {
    logic                     vld;
    logic                     in_band;
    logic [ADDR_W-1:0]        addr;
    logic signed [PROD_W-1:0] prod;
  } mul_st_t;

  logic [BAND_W-1:0]         band_start_q;
  logic [STEP_W-1:0]         band_step_q;
  logic [GAIN_W-1:0]         gain_q;
  logic [CRD_W-1:0]          x1_q, y1_q;
  logic signed [CRD_W:0]     gx_q, gy_q;
  logic [FLT_W-1:0]          faults_q;
  logic [21:0]               fall_prod_q;
  logic [13:0]               fall_q;
  logic [2*FLT_W-1:0]        band_prod_q;
  logic signed [BANDS_W-1:0] band_q;
  logic                      clip_q;
  logic                      rd_oob_q;

  prod_st_t pa_q, pa_d;
  div_st_t  dv_q [IDX_W+1];
  div_st_t  dv_d [IDX_W+1];
  cos_st_t  cs_q, cs_d;
  mul_st_t  ms_q, ms_d;

  logic                      out_vld_q;
  logic [H_W-1:0]            out_h_q;
  logic                      out_done_q;
  logic                      out_sat_q;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [H_W-1:0]            ram_wdata;
  logic                      ram_re;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [H_W-1:0]            ram_rdata;

  logic signed [CRD_W:0]     row_s, col_s;
  logic signed [2*CRD_W+2:0] line_dist;
  logic [2*CRD_W+2:0]        absd;
  logic [BAND_W:0]           mag;
  logic [BAND_W:0]           band_div;
  logic [BAND_W:0]           r2 [IDX_W+1];
  logic signed [PROD_W-1:0]  rise_rnd;
  logic signed [H_W:0]       delta;
  logic signed [H_W:0]       sum;
  logic                      ovf;
  logic [H_W-1:0]            sat_h;

  // setup and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_start_q <= BAND_START_RST;
      band_step_q  <= BAND_STEP_RST;
      gain_q       <= GAIN_RST;
      faults_q     <= '0;
      clip_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BAND_START: band_start_q <= cfg_wdata_i;
          CFG_BAND_STEP:  band_step_q  <= cfg_wdata_i[STEP_W-1:0];
          CFG_GAIN:       gain_q       <= cfg_wdata_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.latch) begin
        faults_q <= faults_q + 1'b1;
        clip_q   <= 1'b0;
      end else if (ms_q.vld && ovf) begin
        clip_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      x1_q        <= start_col_i;
      y1_q        <= start_row_i;
      gx_q        <= $signed({1'b0, end_col_i}) - $signed({1'b0, start_col_i});
      gy_q        <= $signed({1'b0, end_row_i}) - $signed({1'b0, start_row_i});
      fall_prod_q <= {6'd0, gain_q} * FALL_Q8;
    end
    if (cmd_i.band_mul) begin
      band_prod_q <= {16'd0, faults_q} * {16'd0, band_step_q};
      fall_q      <= 14'((fall_prod_q + 22'd128) >> 8);
    end
    if (cmd_i.band_sub) begin
      band_q <= $signed({10'd0, band_start_q}) - $signed({2'b0, band_prod_q});
    end
    if (cmd_i.rd_req) begin
      rd_oob_q <= (32'(read_col_i) >= GRID_W) || (32'(read_row_i) >= GRID_H);
    end
  end

  // cell pipeline: distance products, band test, divider, table, multiply, write back
  always_comb begin
    row_s   = $signed({1'b0, cmd_i.row}) - $signed({1'b0, y1_q});
    col_s   = $signed({1'b0, cmd_i.col}) - $signed({1'b0, x1_q});
    pa_d.vld  = cmd_i.issue;
    pa_d.addr = {cmd_i.row, cmd_i.col};
    pa_d.p1   = gx_q * row_s;
    pa_d.p2   = gy_q * col_s;

    line_dist = {pa_q.p1[2*CRD_W+1], pa_q.p1} - {pa_q.p2[2*CRD_W+1], pa_q.p2};
    absd = line_dist[2*CRD_W+2] ? 19'(-line_dist) : 19'(line_dist);
    mag  = {absd[16:0], 8'd0};
    dv_d[0].vld     = pa_q.vld;
    dv_d[0].addr    = pa_q.addr;
    dv_d[0].in_band = (band_q > 34'sd0) && ($signed({9'd0, mag}) < band_q);
    dv_d[0].rem     = mag[BAND_W-1:0];
    dv_d[0].quo     = '0;

    band_div = {1'b0, band_q[BAND_W-1:0]};
    r2[0]    = '0;
    for (int s = 1; s <= IDX_W; s++) begin
      r2[s]           = {dv_q[s-1].rem, 1'b0};
      dv_d[s].vld     = dv_q[s-1].vld;
      dv_d[s].in_band = dv_q[s-1].in_band;
      dv_d[s].addr    = dv_q[s-1].addr;
      if (r2[s] >= band_div) begin
        dv_d[s].rem = BAND_W'(r2[s] - band_div);
        dv_d[s].quo = {dv_q[s-1].quo[IDX_W-2:0], 1'b1};
      end else begin
        dv_d[s].rem = r2[s][BAND_W-1:0];
        dv_d[s].quo = {dv_q[s-1].quo[IDX_W-2:0], 1'b0};
      end
    end

    cs_d.vld     = dv_q[IDX_W].vld;
    cs_d.in_band = dv_q[IDX_W].in_band;
    cs_d.addr    = dv_q[IDX_W].addr;
    cs_d.cosv    = COS_TAB[dv_q[IDX_W].quo];

    ms_d.vld     = cs_q.vld;
    ms_d.in_band = cs_q.in_band;
    ms_d.addr    = cs_q.addr;
    ms_d.prod    = PROD_W'($signed({cs_q.cosv[COS_W-1], cs_q.cosv} + RISE_BIAS)
                   * $signed({1'b0, gain_q}));

    rise_rnd = (ms_q.prod + 28'sd128) >>> 8;
    delta    = ms_q.in_band ? {{(H_W+1-PROD_W){rise_rnd[PROD_W-1]}}, rise_rnd}
                            : -$signed({19'd0, fall_q});
    sum      = $signed({ram_rdata[H_W-1], ram_rdata}) + delta;
    ovf      = sum[H_W] != sum[H_W-1];
    sat_h    = ovf ? (sum[H_W] ? {1'b1, {(H_W-1){1'b0}}} : {1'b0, {(H_W-1){1'b1}}})
                   : sum[H_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q <= '0;
      cs_q <= '0;
      ms_q <= '0;
      for (int s = 0; s <= IDX_W; s++) dv_q[s] <= '0;
    end else begin
      pa_q <= pa_d;
      cs_q <= cs_d;
      ms_q <= ms_d;
      for (int s = 0; s <= IDX_W; s++) dv_q[s] <= dv_d[s];
    end
  end

  always_comb begin
    sts_o.pipe_idle = !pa_q.vld && !cs_q.vld && !ms_q.vld;
    for (int s = 0; s <= IDX_W; s++) begin
      if (dv_q[s].vld) sts_o.pipe_idle = 1'b0;
    end
    sts_o.out_free = !out_vld_q || out_ready_i;
  end

  assign ram_we    = cmd_i.clr_we || ms_q.vld;
  assign ram_waddr = cmd_i.clr_we ? {cmd_i.row, cmd_i.col} : ms_q.addr;
  assign ram_wdata = cmd_i.clr_we ? '0 : sat_h;
  assign ram_re    = cmd_i.rd_req || cs_q.vld;
  assign ram_raddr = cmd_i.rd_req ? {read_row_i[ROW_W-1:0], read_col_i[COL_W-1:0]}
                                  : cs_q.addr;

  flts_ram #(
    .WIDTH(H_W),
    .DEPTH(CELLS)
  ) u_height_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_read || cmd_i.load_fault) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_read) begin
      out_h_q    <= rd_oob_q ? '0 : ram_rdata;
      out_done_q <= 1'b0;
      out_sat_q  <= 1'b0;
    end else if (cmd_i.load_fault) begin
      out_h_q    <= '0;
      out_done_q <= 1'b1;
      out_sat_q  <= clip_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign height_value_o = out_h_q;
  assign fault_done_o   = out_done_q;
  assign saturated_o    = out_sat_q;

endmodule

>>> src/fault_line_terrain_step_core.sv
// Fault-line terrain grid: 256 x 256 signed Q.8 heights in one RAM. After reset a
// clearing sweep zeroes every cell, during which no item is taken. A read item reads
// the RAM on acceptance; the height enters the output register once that is free.
// A fault item runs the band multiply and band subtract setup states, then streams
// every cell through a 14-stage pipeline (distance products, band test, 10-stage
// restoring divider for the cosine index, table, multiply, read-modify-write) at one
// cell per cycle, bounded by the single write port of the height RAM. One item is
// worked on at a time; a finished result waits in an output register.
module fault_line_terrain_step_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_col, start_row, end_col, end_row, read_col, read_row
  input  logic [47:0]                    s_axis_tdata,
  // req_type
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // height_value
  output logic [31:0]                    m_axis_tdata,
  // fault_done, saturated
  output logic [1:0]                     m_axis_tuser,
  input  logic                           cfg_we_i,
  input  logic [flts_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [flts_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import flts_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic in_fire;

  assign s_axis_tready = in_ready;
  assign in_fire       = s_axis_tvalid && in_ready;

  flts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_read_i (s_axis_tuser[0]),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_ready_o(in_ready)
  );

  flts_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_col_i   (s_axis_tdata[7:0]),
    .start_row_i   (s_axis_tdata[15:8]),
    .end_col_i     (s_axis_tdata[23:16]),
    .end_row_i     (s_axis_tdata[31:24]),
    .read_col_i    (s_axis_tdata[39:32]),
    .read_row_i    (s_axis_tdata[47:40]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .height_value_o(m_axis_tdata),
    .fault_done_o  (m_axis_tuser[0]),
    .saturated_o   (m_axis_tuser[1])
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import flts_pkg::*;

  typedef enum bit {REQ_FAULT = 1'b0, REQ_READ = 1'b1} req_e;

  typedef struct {
    req_e     req;
    bit [7:0] sc, sr, ec, er, rc, rr;
    bit       typed;
    int       typed_h;
  } stim_t;

  typedef struct {
    logic signed [31:0] height;
    bit                 done;
    bit                 sat;
  } result_t;

  localparam int STALL_LIMIT = 300000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  fault_line_terrain_step_core u_top (.*);

  // model state
  int          grid_height [GRID_W*GRID_H];
  shortint     cos_q8 [COS_ENTRIES];
  bit   [15:0] fault_count;
  bit   [23:0] band_start_q;
  bit   [15:0] band_step_q;
  bit   [15:0] gain_q;

  result_t     pending_results [$];
  int          fails;
  int          faults_sent;
  int          reads_sent;
  int          idle_cycles;
  bit          calm_sink;
  int          sink_hold;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void make_cos_table();
    longint unsigned x, x2, r, sub, kk, q8;
    longint unsigned divs [5] = '{90, 56, 30, 12, 2};
    bit neg;
    for (int k = 0; k < COS_ENTRIES; k++) begin
      neg = (2 * k > COS_ENTRIES);
      kk  = neg ? COS_ENTRIES - k : k;
      x   = (64'd843314856 * kk) / COS_ENTRIES;
      x2  = (x * x) >> 28;
      r   = 64'd268435456;
      for (int i = 0; i < 5; i++) begin
        sub = ((x2 * r) >> 28) / divs[i];
        r   = (sub >= 64'd268435456) ? 0 : 64'd268435456 - sub;
      end
      q8 = (r + (64'd1 << 19)) >> 20;
      cos_q8[k] = neg ? -shortint'(q8) : shortint'(q8);
    end
  endfunction

  function automatic longint round_q8(longint v);
    return (v + 128) >>> 8;
  endfunction

  // run one fault pass over the grid, return the clip flag
  function automatic bit apply_fault_line(bit [7:0] sc, sr, ec, er);
    longint gx, gy, band, fall, line_dist, mag, idx, h;
    bit clipped;
    clipped = 0;
    gx = longint'(ec) - longint'(sc);
    gy = longint'(er) - longint'(sr);
    fault_count = fault_count + 16'd1;
    band = longint'(band_start_q) - longint'(fault_count) * longint'(band_step_q);
    fall = round_q8(51 * longint'(gain_q));
    for (int row = 0; row < GRID_H; row++) begin
      for (int col = 0; col < GRID_W; col++) begin
        line_dist = gx * (row - longint'(sr)) - gy * (col - longint'(sc));
        mag  = (line_dist < 0 ? -line_dist : line_dist) * 256;
        h    = grid_height[row*GRID_W + col];
        if (mag < band) begin
          idx = (mag * COS_ENTRIES) / band;
          if (idx >= COS_ENTRIES) idx = COS_ENTRIES - 1;
          h += round_q8((205 + longint'(cos_q8[idx])) * longint'(gain_q));
        end else begin
          h -= fall;
        end
        if (h > 64'sd2147483647) begin
          h = 64'sd2147483647;
          clipped = 1;
        end
        if (h < -64'sd2147483648) begin
          h = -64'sd2147483648;
          clipped = 1;
        end
        grid_height[row*GRID_W + col] = int'(h);
      end
    end
    return clipped;
  endfunction

  function automatic result_t predict_terrain(stim_t s);
    result_t res;
    if (s.req == REQ_FAULT) begin
      res.height = 0;
      res.done   = 1;
      res.sat    = apply_fault_line(s.sc, s.sr, s.ec, s.er);
    end else begin
      res.height = grid_height[int'(s.rr)*GRID_W + int'(s.rc)];
      res.done   = 0;
      res.sat    = 0;
      if (s.typed) res.height = s.typed_h;
    end
    return res;
  endfunction

  task automatic send_item(stim_t s);
    int gap;
    if ($urandom_range(0, 3) == 0) gap = 0;
    else if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 40);
    else gap = $urandom_range(1, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= s.req;
    s_axis_tdata  <= {s.rr, s.rc, s.er, s.ec, s.sr, s.sc};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_terrain(s));
    if (s.req == REQ_FAULT) faults_sent++;
    else reads_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_BAND_START: band_start_q = val[23:0];
      CFG_BAND_STEP:  band_step_q  = val[15:0];
      default:        gain_q       = val[15:0];
    endcase
  endtask

  function automatic stim_t read_at(bit [7:0] c, r);
    stim_t s;
    s = '{REQ_READ, $urandom, $urandom, $urandom, $urandom, c, r, 0, 0};
    return s;
  endfunction

  function automatic stim_t fault_at(bit [7:0] sc, sr, ec, er);
    stim_t s;
    s = '{REQ_FAULT, sc, sr, ec, er, $urandom, $urandom, 0, 0};
    return s;
  endfunction

  // result side: check each item, random backpressure
  always @(posedge clk_i) begin
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: height %0d", $signed(m_axis_tdata));
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.height) begin
          $error("height_value: expected %0d, got %0d", want.height, $signed(m_axis_tdata));
          fails++;
        end
        if (m_axis_tuser[0] !== want.done) begin
          $error("fault_done: expected %0d, got %0d", want.done, m_axis_tuser[0]);
          fails++;
        end
        if (m_axis_tuser[1] !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, m_axis_tuser[1]);
          fails++;
        end
      end
    end
    if (calm_sink) begin
      m_axis_tready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 9) < 3) begin
      sink_hold <= ($urandom_range(0, 14) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[fault_line_terrain_step_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_t directed [$];
    stim_t s;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    fails = 0; faults_sent = 0; reads_sent = 0; idle_cycles = 0;
    calm_sink = 0; sink_hold = 0;
    foreach (grid_height[i]) grid_height[i] = 0;
    fault_count  = 0;
    band_start_q = 24'd3840000;
    band_step_q  = 16'd5248;
    gain_q       = 16'd717;
    make_cos_table();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // cleared grid reads zero at three corners
    s = read_at(8'd0, 8'd0);     s.typed = 1; directed.push_back(s);
    s = read_at(8'd255, 8'd255); s.typed = 1; directed.push_back(s);
    s = read_at(8'd255, 8'd0);   s.typed = 1; directed.push_back(s);
    directed.push_back(fault_at(8'd0, 8'd0, 8'd255, 8'd255));
    directed.push_back(read_at(8'd0, 8'd0));
    directed.push_back(read_at(8'd255, 8'd0));
    directed.push_back(read_at(8'd128, 8'd128));
    // coincident points: every cell at distance zero
    directed.push_back(fault_at(8'd10, 8'd10, 8'd10, 8'd10));
    directed.push_back(read_at(8'd10, 8'd10));
    directed.push_back(read_at(8'd200, 8'd3));
    directed.push_back(fault_at(8'd255, 8'd0, 8'd0, 8'd255));
    directed.push_back(read_at(8'd0, 8'd255));
    directed.push_back(read_at(8'd255, 8'd255));
    calm_sink = 1;
    foreach (directed[i]) send_item(directed[i]);
    calm_sink = 0;
    drain_results();

    // band not positive, largest gain: every cell falls
    write_reg(CFG_BAND_START, 0);
    write_reg(CFG_BAND_STEP, 16'hFFFF);
    write_reg(CFG_GAIN, 16'hFFFF);
    send_item(fault_at(8'd40, 8'd50, 8'd60, 8'd70));
    send_item(read_at(8'd1, 8'd2));
    send_item(read_at(8'd254, 8'd253));
    drain_results();

    // widest band, no shrink, zero gain
    write_reg(CFG_BAND_START, 24'hFFFFFF);
    write_reg(CFG_BAND_STEP, 0);
    write_reg(CFG_GAIN, 0);
    send_item(fault_at(8'd3, 8'd250, 8'd250, 8'd3));
    send_item(read_at(8'd77, 8'd77));
    drain_results();

    // narrow band around random lines
    write_reg(CFG_BAND_START, $urandom_range(20000, 200000));
    write_reg(CFG_BAND_STEP, $urandom_range(0, 2000));
    write_reg(CFG_GAIN, $urandom_range(100, 40000));
    for (int n = 0; n < 80; n++) begin
      if (n == 40) drain_results();
      calm_sink = (n >= 55 && n < 65);
      if ($urandom_range(0, 11) == 0) s = fault_at($urandom, $urandom, $urandom, $urandom);
      else s = read_at($urandom, $urandom);
      send_item(s);
    end
    calm_sink = 0;
    drain_results();

    $display("Covered %0d fault passes and %0d height reads over four register settings,",
             faults_sent, reads_sent);
    $display("including an empty band, the widest band and coincident line points.");
    if (fails == 0) begin
      $display("[fault_line_terrain_step_core] OK");
    end else begin
      $display("[fault_line_terrain_step_core] ERROR");
    end
    $finish;
  end

endmodule
